// ----- design/urc_pkg.sv -----
`default_nettype none

package urc_pkg;

  // default timing parameters
  localparam int TICKS_PER_MS_DEF = 1000;
  localparam int TRIG_HIGH_US_DEF = 10;
  localparam int TRIG_LOW_US_DEF  = 4;

  // fixed field widths
  localparam int TICKS_W   = 18;
  localparam int MS_W      = 16;
  localparam int DIST_W    = 16;
  localparam int REFRESH_W = 16;
  localparam int SPEED_W   = 10;
  localparam int TIMEOUT_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  // register reset values
  localparam logic [REFRESH_W-1:0] REFRESH_RST = 16'd0;
  localparam logic [SPEED_W-1:0]   SPEED_RST   = 10'd343;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd30;

  // distance = speed * width / 20000 = ((speed * width) >> 5) / 625
  // x / 625 == (x * ceil(2^33 / 625)) >> 33, exact for x < 2^23
  localparam int PROD_W      = SPEED_W + TICKS_W;   // 28
  localparam int PRE_SHIFT   = 5;
  localparam int X_W         = PROD_W - PRE_SHIFT;  // 23
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 33;
  localparam int MULT_W      = X_W + RECIP_W;       // 47
  localparam int Q_W         = MULT_W - RECIP_SHIFT; // 14
  localparam logic [RECIP_W-1:0] RECIP_625 = 24'd13743896;

  typedef struct packed {
    logic echo_level;
    logic request;
  } urc_in_t;

  typedef struct packed {
    logic              trigger_level;
    logic [DIST_W-1:0] distance_cm;
    logic              reading_done;
    logic              busy_res;
  } urc_out_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_TRIG_LOW   = 3'd1,
    PH_TRIG_HIGH  = 3'd2,
    PH_WAIT_END   = 3'd3,
    PH_WAIT_START = 3'd4,
    PH_MEASURE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [REFRESH_W-1:0] refresh_ms;
    logic [TICKS_W-1:0]   limit;
  } cfg_t;

  typedef struct packed {
    logic               trig;
    logic               done;
    logic               busy;
    logic               finish;
    logic [TICKS_W-1:0] width;
  } step_t;

endpackage

`default_nettype wire

// ----- design/urc_scale.sv -----
`default_nettype none

// Product to centimetres: divide by 20000 via shift and reciprocal multiply.
// Largest product 1023 * 262143 gives 13408, so no saturation is needed.
module urc_scale (
  input  wire logic [urc_pkg::PROD_W-1:0] prod,
  output logic      [urc_pkg::DIST_W-1:0] dist_cm
);

  logic [urc_pkg::X_W-1:0]    x;
  logic [urc_pkg::MULT_W-1:0] full;
  logic [urc_pkg::Q_W-1:0]    q;

  assign x       = prod[urc_pkg::PROD_W-1:urc_pkg::PRE_SHIFT];
  assign full    = urc_pkg::MULT_W'(x) * urc_pkg::MULT_W'(urc_pkg::RECIP_625);
  assign q       = full[urc_pkg::MULT_W-1:urc_pkg::RECIP_SHIFT];
  assign dist_cm = urc_pkg::DIST_W'(q);

endmodule

`default_nettype wire

// ----- design/urc_ctrl.sv -----
`default_nettype none

// Time base and measurement sequencer, one tick per enabled cycle.
module urc_ctrl #(
  parameter int TICKS_PER_MS = urc_pkg::TICKS_PER_MS_DEF,
  parameter int TRIG_HIGH_US = urc_pkg::TRIG_HIGH_US_DEF,
  parameter int TRIG_LOW_US  = urc_pkg::TRIG_LOW_US_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire urc_pkg::urc_in_t item,
  input  wire urc_pkg::cfg_t    cfg,
  output urc_pkg::step_t        step
);

  localparam int PRE_W = $clog2(TICKS_PER_MS + 1);

  urc_pkg::phase_t                phase_r, phase_nxt;
  logic [urc_pkg::TICKS_W-1:0]    ticks_r, ticks_nxt, ticks_inc;
  logic [urc_pkg::TICKS_W-1:0]    width_r, width_nxt;
  logic [PRE_W-1:0]               pre_r, pre_nxt, pre_inc;
  logic [urc_pkg::MS_W-1:0]       ms_r, ms_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urc_pkg::PH_IDLE;
      ticks_r <= '0;
      width_r <= '0;
      pre_r   <= '0;
      ms_r    <= '1;
    end else if (en) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      width_r <= width_nxt;
      pre_r   <= pre_nxt;
      ms_r    <= ms_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    ticks_nxt   = ticks_r;
    width_nxt   = width_r;
    step.trig   = 1'b0;
    step.done   = 1'b0;
    step.finish = 1'b0;
    step.width  = '0;

    // millisecond time base, saturating
    pre_inc = pre_r + PRE_W'(1);
    pre_nxt = pre_inc;
    ms_nxt  = ms_r;
    if (pre_inc >= PRE_W'(TICKS_PER_MS)) begin
      pre_nxt = '0;
      if (ms_r != '1) ms_nxt = ms_r + urc_pkg::MS_W'(1);
    end

    ticks_inc = (ticks_r != '1) ? ticks_r + urc_pkg::TICKS_W'(1) : ticks_r;

    unique case (phase_r)
      urc_pkg::PH_IDLE: begin
        if (item.request) begin
          if (ms_nxt < cfg.refresh_ms) begin
            step.done = 1'b1;   // too soon: answer with held distance
          end else begin
            ms_nxt    = '0;
            pre_nxt   = '0;
            phase_nxt = urc_pkg::PH_TRIG_LOW;
            ticks_nxt = urc_pkg::TICKS_W'(1);
          end
        end
      end
      urc_pkg::PH_TRIG_LOW: begin
        if (ticks_r < urc_pkg::TICKS_W'(TRIG_LOW_US)) begin
          ticks_nxt = ticks_r + urc_pkg::TICKS_W'(1);
        end else begin
          phase_nxt = urc_pkg::PH_TRIG_HIGH;
          ticks_nxt = urc_pkg::TICKS_W'(1);
          step.trig = 1'b1;
        end
      end
      urc_pkg::PH_TRIG_HIGH: begin
        if (ticks_r < urc_pkg::TICKS_W'(TRIG_HIGH_US)) begin
          ticks_nxt = ticks_r + urc_pkg::TICKS_W'(1);
          step.trig = 1'b1;
        end else begin
          phase_nxt = urc_pkg::PH_WAIT_END;
          ticks_nxt = '0;
          width_nxt = '0;
        end
      end
      default: begin
        ticks_nxt = ticks_inc;
        if (phase_r == urc_pkg::PH_WAIT_END) begin
          if (!item.echo_level) phase_nxt = urc_pkg::PH_WAIT_START;
        end else if (phase_r == urc_pkg::PH_WAIT_START) begin
          if (item.echo_level) begin
            phase_nxt = urc_pkg::PH_MEASURE;
            width_nxt = urc_pkg::TICKS_W'(1);
          end
        end else if (phase_r == urc_pkg::PH_MEASURE) begin
          if (item.echo_level) begin
            if (width_r != '1) width_nxt = width_r + urc_pkg::TICKS_W'(1);
          end else begin
            step.finish = 1'b1;   // falling edge beats timeout
            step.width  = width_r;
          end
        end else begin
          step.finish = 1'b1;     // bad phase code: treat as timeout
        end
        if (!step.finish && ticks_inc >= cfg.limit) begin
          step.finish = 1'b1;
          step.width  = '0;
        end
        if (step.finish) begin
          phase_nxt = urc_pkg::PH_IDLE;
          ticks_nxt = '0;
          step.done = 1'b1;
        end
      end
    endcase

    step.busy = (phase_nxt != urc_pkg::PH_IDLE);
  end

  a_trig_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (en && step.trig) |->
      (phase_r == urc_pkg::PH_TRIG_LOW || phase_r == urc_pkg::PH_TRIG_HIGH))
    else $error("trigger outside trigger phases");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (en && step.done) |=> (phase_r == urc_pkg::PH_IDLE))
    else $error("answered item left sequencer busy");

  a_width_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (en && step.finish && step.width != '0) |-> (phase_r == urc_pkg::PH_MEASURE))
    else $error("nonzero width outside measurement");

endmodule

`default_nettype wire

// ----- design/ultrasonic_range_controller.sv -----
`default_nettype none

// Result path: input register, stage 2, output register; a stall at out_ready holds it.
// Throughput: one item per cycle unless out_ready stalls; each item is one microsecond tick,
// one result per item. Rate is set by the sequencer step and two-stage distance multiply.
// Reset (rst_n low, synchronous): pipeline empty, sequencer idle, held distance 0,
// last trigger treated as long ago, registers at refresh 0 / speed 343 / timeout 30 ms.
module ultrasonic_range_controller #(
  parameter int TICKS_PER_MS = urc_pkg::TICKS_PER_MS_DEF,
  parameter int TRIG_HIGH_US = urc_pkg::TRIG_HIGH_US_DEF,
  parameter int TRIG_LOW_US  = urc_pkg::TRIG_LOW_US_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire urc_pkg::urc_in_t              in_data,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output urc_pkg::urc_out_t                  out_data,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [urc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [urc_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------
  // Configuration registers. The timeout is kept as a tick limit,
  // scaled at write time so the sequencer compares directly.
  // ---------------------------------------------------------------
  logic [urc_pkg::REFRESH_W-1:0] refresh_r;
  logic [urc_pkg::SPEED_W-1:0]   speed_r;
  logic [urc_pkg::TICKS_W-1:0]   limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= urc_pkg::REFRESH_RST;
      speed_r   <= urc_pkg::SPEED_RST;
      limit_r   <= urc_pkg::TICKS_W'(urc_pkg::TIMEOUT_RST) * urc_pkg::TICKS_W'(TICKS_PER_MS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        urc_pkg::CFG_REFRESH: refresh_r <= cfg_wdata[urc_pkg::REFRESH_W-1:0];
        urc_pkg::CFG_SPEED:   speed_r   <= cfg_wdata[urc_pkg::SPEED_W-1:0];
        urc_pkg::CFG_TIMEOUT:
          limit_r <= urc_pkg::TICKS_W'(cfg_wdata[urc_pkg::TIMEOUT_W-1:0])
                     * urc_pkg::TICKS_W'(TICKS_PER_MS);
        default: ;            // unused index: write dropped
      endcase
    end
  end

  urc_pkg::cfg_t cfg;
  assign cfg.refresh_ms = refresh_r;
  assign cfg.limit      = limit_r;

  // ---------------------------------------------------------------
  // Pipeline handshake. Each stage advances when the next one is
  // empty or draining; ready ripples back from out_ready.
  // ---------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_move, s2_move, s2_ready;

  assign s2_move  = s2_valid_r & (~out_valid_r | out_ready);
  assign s2_ready = ~s2_valid_r | s2_move;
  assign s1_move  = s1_valid_r & s2_ready;
  assign in_ready = ~s1_valid_r | s1_move;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) s1_valid_r <= 1'b1;
      else if (s1_move)         s1_valid_r <= 1'b0;
      if (s1_move)              s2_valid_r <= 1'b1;
      else if (s2_move)         s2_valid_r <= 1'b0;
      if (s2_move)              out_valid_r <= 1'b1;
      else if (out_ready)       out_valid_r <= 1'b0;
    end
  end

  // stage 1: input register
  urc_pkg::urc_in_t s1_item_r;
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r <= in_data;
  end

  // sequencer: state advances as the stage 1 item moves on
  urc_pkg::step_t step;

  urc_ctrl #(
    .TICKS_PER_MS (TICKS_PER_MS),
    .TRIG_HIGH_US (TRIG_HIGH_US),
    .TRIG_LOW_US  (TRIG_LOW_US)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_move),
    .item  (s1_item_r),
    .cfg   (cfg),
    .step  (step)
  );

  // stage 2: sequencer outputs plus speed * width product
  // (width is zero unless the item finishes a measurement)
  logic                         s2_trig_r, s2_done_r, s2_busy_r, s2_fin_r;
  logic [urc_pkg::PROD_W-1:0]   s2_prod_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_trig_r <= step.trig;
      s2_done_r <= step.done;
      s2_busy_r <= step.busy;
      s2_fin_r  <= step.finish;
      s2_prod_r <= urc_pkg::PROD_W'(speed_r) * urc_pkg::PROD_W'(step.width);
    end
  end

  // stage 3: reciprocal scaling, held distance and output register
  logic [urc_pkg::DIST_W-1:0] dist_cm;
  logic [urc_pkg::DIST_W-1:0] held_r;
  logic [urc_pkg::DIST_W-1:0] held_nxt;
  urc_pkg::urc_out_t          out_data_r;

  urc_scale u_scale (
    .prod    (s2_prod_r),
    .dist_cm (dist_cm)
  );

  assign held_nxt = s2_fin_r ? dist_cm : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (s2_move) begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_data_r.trigger_level <= s2_trig_r;
      out_data_r.distance_cm   <= held_nxt;
      out_data_r.reading_done  <= s2_done_r;
      out_data_r.busy_res      <= s2_busy_r;
    end
  end

  assign out_data = out_data_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("input stalled with an empty stage");

  a_held_update: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != $past(held_r)) |-> $past(s2_move && s2_fin_r))
    else $error("held distance changed without a finished measurement");

  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_fin_r) |-> (s2_done_r && !s2_busy_r))
    else $error("finished item not flagged as answered");

endmodule

`default_nettype wire
